@@ hw/rtl/dcf_pkg.sv @@
// Shared types and constants for the deadband change filter.
// Holds the per-channel record layout, the input item layout and the
// configuration register map. No dependencies.
package dcf_pkg;

    // Store depth and its address width. The depth is a power of two, so the
    // channel field wraps into the store by dropping its upper bits.
    localparam int CHANNELS = 1024;
    localparam int IDX_W    = $clog2(CHANNELS);

    // Field widths fixed by the sample format.
    localparam int CH_W     = 10;
    localparam int TS_W     = 48;
    localparam int VAL_W    = 48;
    localparam int OTHER_W  = 32;
    localparam int QUAL_W   = 16;
    localparam int DB_W     = 47;
    localparam int IVL_W    = 32;

    // Stream payload widths; the data widths are padded to whole bytes.
    localparam int S_DATA_W = 160;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 16;
    localparam int M_USER_W = 1;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DB_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE       = 2'd0,
        CFG_DEADBAND     = 2'd1,
        CFG_MIN_INTERVAL = 2'd2,
        CFG_MAX_INTERVAL = 2'd3
    } cfg_index_t;

    // Reset values of the configuration registers.
    localparam logic [IVL_W-1:0] MIN_INTERVAL_RST = 32'd250;
    localparam logic [IVL_W-1:0] MAX_INTERVAL_RST = 32'd60000;

    typedef struct packed {
        logic              enable;
        logic [DB_W-1:0]   deadband;
        logic [IVL_W-1:0]  min_interval;
        logic [IVL_W-1:0]  max_interval;
    } cfg_t;

    // One sample as it arrives on the input stream.
    typedef struct packed {
        logic [CH_W-1:0]          channel;
        logic [TS_W-1:0]          timestamp;
        logic signed [VAL_W-1:0]  value;
        logic                     value_present;
        logic [OTHER_W-1:0]       other_code;
        logic [QUAL_W-1:0]        quality;
        logic                     quality_present;
    } item_t;

    // Stored record of the last kept sample of one channel.
    typedef struct packed {
        logic [TS_W-1:0]     last_time;
        logic [VAL_W-1:0]    last_value;
        logic                last_value_valid;
        logic [OTHER_W-1:0]  last_other;
        logic [QUAL_W-1:0]   last_quality;
        logic                last_quality_valid;
    } rec_t;

    // Store address of a channel.
    function automatic logic [IDX_W-1:0] chan_addr(input logic [CH_W-1:0] ch);
        chan_addr = IDX_W'(ch);
    endfunction

endpackage

@@ hw/rtl/dcf_decide.sv @@
// Keep/suppress decision for one sample against its channel's stored record.
// Purely combinational. Depends on dcf_pkg.
module dcf_decide
    import dcf_pkg::*;
(
    input  item_t item,
    input  rec_t  rec,
    input  cfg_t  cfg,
    output logic  keep
);

    logic signed [TS_W:0]  since;
    logic                  never;
    logic                  max_ok;
    logic                  min_ok;
    logic signed [VAL_W:0] vdiff;
    logic signed [VAL_W:0] db;
    logic                  beyond;
    logic                  changed;

    // Elapsed time as a signed difference; time going backwards is negative.
    assign since  = $signed({1'b0, item.timestamp}) - $signed({1'b0, rec.last_time});
    assign never  = (rec.last_time == '0);
    assign max_ok = never || (since >= $signed({{(TS_W + 1 - IVL_W){1'b0}}, cfg.max_interval}));
    assign min_ok = never || (since >= $signed({{(TS_W + 1 - IVL_W){1'b0}}, cfg.min_interval}));

    // The magnitude test is split into two compares against +deadband and -deadband.
    assign vdiff  = $signed({item.value[VAL_W-1], item.value})
                  - $signed({rec.last_value[VAL_W-1], rec.last_value});
    assign db     = $signed({{(VAL_W + 1 - DB_W){1'b0}}, cfg.deadband});
    assign beyond = (vdiff > db) || (vdiff < -db);

    // Quality first, then numeric value, then value presence, then the text digest.
    always_comb
    begin
        priority if ((item.quality_present != rec.last_quality_valid) ||
                     (item.quality_present && (item.quality != rec.last_quality)))
        begin
            changed = 1'b1;
        end
        else if (item.value_present && rec.last_value_valid)
        begin
            changed = beyond;
        end
        else if (item.value_present != rec.last_value_valid)
        begin
            changed = 1'b1;
        end
        else
        begin
            changed = (item.other_code != rec.last_other);
        end
    end

    assign keep = !cfg.enable || (changed && min_ok) || max_ok;

endmodule

@@ hw/rtl/deadband_change_filter.sv @@
// Per-channel deadband report-by-exception filter, top level.
// Path: each sample is registered in the decision stage and its result
// in the output register, which transfers it when the output is ready.
// Throughput: one sample per cycle while the output is ready, set by the
// single read-modify-write of the channel store, forwarding between neighbors.
// Reset: configuration returns to its defaults and a clearing pass over all
// CHANNELS entries (1024) zeroes the store; no input is taken until it ends.
module deadband_change_filter
    import dcf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // Fields from bit 0: channel, timestamp, value, other_code, quality, zero pad.
    input  logic [S_DATA_W-1:0]   s_axis_tdata,
    // Fields from bit 0: value_present, quality_present.
    input  logic [S_USER_W-1:0]   s_axis_tuser,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // Fields from bit 0: out_channel, zero pad.
    output logic [M_DATA_W-1:0]   m_axis_tdata,
    // Fields from bit 0: keep.
    output logic [M_USER_W-1:0]   m_axis_tuser,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    rec_t             mem [CHANNELS];

    cfg_t             cfg_reg;
    logic [IDX_W:0]   clr_cnt_reg;
    logic             clearing;

    item_t            in_item;
    logic [IDX_W-1:0] in_addr;
    logic             accept;

    logic             s1_valid_reg;
    logic             s1_valid_next;
    item_t            s1_item_reg;
    logic [IDX_W-1:0] s1_addr;
    rec_t             mem_q_reg;
    rec_t             fwd_rec_reg;
    logic             fwd_sel_reg;
    rec_t             s1_rec;
    rec_t             new_rec;
    logic             keep;
    logic             s1_adv;
    logic             wr_en;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_keep_reg;
    logic [CH_W-1:0]  out_chan_reg;

    // Unpack the input transfer.
    always_comb
    begin
        in_item.channel         = s_axis_tdata[9:0];
        in_item.timestamp       = s_axis_tdata[57:10];
        in_item.value           = $signed(s_axis_tdata[105:58]);
        in_item.other_code      = s_axis_tdata[137:106];
        in_item.quality         = s_axis_tdata[153:138];
        in_item.value_present   = s_axis_tuser[0];
        in_item.quality_present = s_axis_tuser[1];
    end

    assign in_addr = chan_addr(in_item.channel);
    assign s1_addr = chan_addr(s1_item_reg.channel);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable       <= 1'b1;
            cfg_reg.deadband     <= '0;
            cfg_reg.min_interval <= MIN_INTERVAL_RST;
            cfg_reg.max_interval <= MAX_INTERVAL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_ENABLE:       cfg_reg.enable       <= cfg_data[0];
                CFG_DEADBAND:     cfg_reg.deadband     <= cfg_data[DB_W-1:0];
                CFG_MIN_INTERVAL: cfg_reg.min_interval <= cfg_data[IVL_W-1:0];
                CFG_MAX_INTERVAL: cfg_reg.max_interval <= cfg_data[IVL_W-1:0];
            endcase
        end
    end

    // Clearing pass after reset: the top bit of the counter marks completion.
    assign clearing = !clr_cnt_reg[IDX_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (clearing)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // Decision stage: the record comes from the store, or from the previous
    // sample when that one wrote the same entry at the edge of the read.
    assign s1_rec = fwd_sel_reg ? fwd_rec_reg : mem_q_reg;

    dcf_decide u_decide (
        .item (s1_item_reg),
        .rec  (s1_rec),
        .cfg  (cfg_reg),
        .keep (keep)
    );

    always_comb
    begin
        new_rec.last_time          = s1_item_reg.timestamp;
        new_rec.last_value         = s1_item_reg.value;
        new_rec.last_value_valid   = s1_item_reg.value_present;
        new_rec.last_other         = s1_item_reg.other_code;
        new_rec.last_quality       = s1_item_reg.quality;
        new_rec.last_quality_valid = s1_item_reg.quality_present;
    end

    // Handshake: the decision stage moves on whenever the output register is
    // free or being emptied; without output stalls a new sample enters every cycle.
    assign s1_adv        = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !clearing && (!s1_valid_reg || s1_adv);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign wr_en         = s1_adv && keep;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
            s1_valid_next  = 1'b0;
        end
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Channel store: one write port shared by clearing and kept samples,
    // one registered read port for the entering sample.
    always_ff @(posedge clk)
    begin
        if (clearing)
        begin
            mem[clr_cnt_reg[IDX_W-1:0]] <= '0;
        end
        else if (wr_en)
        begin
            mem[s1_addr] <= new_rec;
        end
        if (accept)
        begin
            mem_q_reg <= mem[in_addr];
        end
    end

    // Stage payload and forwarding of a same-entry write.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= in_item;
            fwd_rec_reg <= new_rec;
            fwd_sel_reg <= wr_en && (s1_addr == in_addr);
        end
        if (s1_adv)
        begin
            out_keep_reg <= keep;
            out_chan_reg <= s1_item_reg.channel;
        end
    end

    // Output transfer.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(M_DATA_W - CH_W){1'b0}}, out_chan_reg};
    assign m_axis_tuser  = out_keep_reg;

endmodule

@@ dv/deadband_change_filter_tb.sv @@
// Self-checking testbench for the deadband change filter.
// Predicts the keep decision per sample from its own channel store and register copy.
// Depends on dcf_pkg and deadband_change_filter only.
`timescale 1ns / 1ps

module deadband_change_filter_tb;
    import dcf_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int POOL           = 12;

    // Expected outcome of one sample.
    typedef struct packed {
        logic            keep;
        logic [CH_W-1:0] channel;
    } verdict_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // Fields from bit 0: channel, timestamp, value, other_code, quality, zero pad.
    logic [S_DATA_W-1:0]   s_axis_tdata = '0;
    // Fields from bit 0: value_present, quality_present.
    logic [S_USER_W-1:0]   s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // Fields from bit 0: out_channel, zero pad.
    logic [M_DATA_W-1:0]   m_axis_tdata;
    // Fields from bit 0: keep.
    logic [M_USER_W-1:0]   m_axis_tuser;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Register copy, at reset values.
    logic             mir_enable = 1'b1;
    logic [DB_W-1:0]  mir_deadband = '0;
    logic [IVL_W-1:0] mir_min = MIN_INTERVAL_RST;
    logic [IVL_W-1:0] mir_max = MAX_INTERVAL_RST;

    // Channel store copy.
    logic [TS_W-1:0]    st_time  [CHANNELS];
    logic [VAL_W-1:0]   st_value [CHANNELS];
    logic               st_vv    [CHANNELS];
    logic [OTHER_W-1:0] st_other [CHANNELS];
    logic [QUAL_W-1:0]  st_qual  [CHANNELS];
    logic               st_qv    [CHANNELS];

    // Per-channel history of the sequences that the random traffic builds on.
    logic [CH_W-1:0]    hot_ch  [POOL];
    logic [TS_W-1:0]    hot_ts  [POOL];
    logic [VAL_W-1:0]   hot_val [POOL];
    logic               hot_vp  [POOL];
    logic [OTHER_W-1:0] hot_oth [POOL];
    logic [QUAL_W-1:0]  hot_q   [POOL];
    logic               hot_qp  [POOL];

    verdict_t    pending_verdicts[$];
    int unsigned mismatches = 0;
    int unsigned idle_cycles = 0;
    int unsigned rdy_hold = 0;
    bit          tx_gaps = 1'b1;
    bit          rx_stalls = 1'b1;

    deadband_change_filter u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        if (mismatches < 30)
            $display("[%0t] ERROR: %s", $realtime, what);
        mismatches++;
    endtask

    // Decide keep or suppress for one accepted sample and update the store copy.
    function automatic logic judge_sample(input item_t s);
        logic [IDX_W-1:0]   a;
        logic signed [63:0] since;
        logic signed [63:0] delta;
        logic               never;
        logic               max_ok;
        logic               min_ok;
        logic               changed;
        logic               keep;
        a = s.channel[IDX_W-1:0];
        if (!mir_enable)
        begin
            keep = 1'b1;
        end
        else
        begin
            since  = $signed({16'd0, s.timestamp}) - $signed({16'd0, st_time[a]});
            never  = (st_time[a] == '0);
            max_ok = never || (since >= $signed({32'd0, mir_max}));
            min_ok = never || (since >= $signed({32'd0, mir_min}));
            changed = 1'b0;
            if (s.quality_present != st_qv[a] ||
                (s.quality_present && s.quality != st_qual[a]))
            begin
                changed = 1'b1;
            end
            else if (s.value_present && st_vv[a])
            begin
                delta = {{16{s.value[VAL_W-1]}}, s.value}
                      - {{16{st_value[a][VAL_W-1]}}, st_value[a]};
                if (delta < 0)
                    delta = -delta;
                changed = (delta > {17'd0, mir_deadband});
            end
            else if (s.value_present != st_vv[a])
            begin
                changed = 1'b1;
            end
            else
            begin
                changed = (s.other_code != st_other[a]);
            end
            keep = (changed && min_ok) || max_ok;
        end
        if (keep)
        begin
            st_time[a]  = s.timestamp;
            st_value[a] = s.value;
            st_vv[a]    = s.value_present;
            st_other[a] = s.other_code;
            st_qual[a]  = s.quality;
            st_qv[a]    = s.quality_present;
        end
        return keep;
    endfunction

    function automatic item_t make_sample(input int ch, input logic [TS_W-1:0] ts,
                                          input logic [VAL_W-1:0] val, input logic vp,
                                          input logic [OTHER_W-1:0] oth,
                                          input logic [QUAL_W-1:0] q, input logic qp);
        item_t s;
        s.channel         = CH_W'(ch);
        s.timestamp       = ts;
        s.value           = val;
        s.value_present   = vp;
        s.other_code      = oth;
        s.quality         = q;
        s.quality_present = qp;
        return s;
    endfunction

    // Start a fresh set of channels for the random traffic.
    function automatic void seed_pool();
        for (int k = 0; k < POOL; k++)
        begin
            hot_ch[k]  = CH_W'($urandom);
            hot_ts[k]  = TS_W'($urandom_range(1, 100000));
            hot_val[k] = VAL_W'({$urandom, $urandom});
            hot_vp[k]  = ($urandom_range(0, 99) < 80);
            hot_oth[k] = $urandom;
            hot_q[k]   = QUAL_W'($urandom);
            hot_qp[k]  = 1'($urandom_range(0, 1));
        end
    endfunction

    // Mostly plausible per-channel sequences near the interval and deadband
    // edges, with some fully random samples mixed in.
    function automatic item_t next_sample();
        item_t             s;
        int                k;
        int unsigned       r;
        logic [TS_W-1:0]   step;
        logic [VAL_W-1:0]  dv;
        if ($urandom_range(0, 99) < 15)
        begin
            s.channel         = CH_W'($urandom);
            s.timestamp       = TS_W'({$urandom, $urandom});
            s.value           = VAL_W'({$urandom, $urandom});
            s.value_present   = 1'($urandom_range(0, 1));
            s.other_code      = $urandom;
            s.quality         = QUAL_W'($urandom);
            s.quality_present = 1'($urandom_range(0, 1));
            return s;
        end
        k = $urandom_range(0, POOL - 1);
        s.channel = hot_ch[k];

        // Time step relative to the configured intervals.
        r = $urandom_range(0, 99);
        if (r < 30)
            step = TS_W'($urandom_range(0, mir_min));
        else if (r < 50)
            step = TS_W'(mir_min) + TS_W'($urandom_range(0, 2)) - TS_W'(1);
        else if (r < 75)
            step = TS_W'($urandom_range(mir_min, mir_max));
        else if (r < 85)
            step = TS_W'(mir_max) + TS_W'($urandom_range(0, 2)) - TS_W'(1);
        else if (r < 90)
            step = -TS_W'($urandom_range(1, 1000));
        else
            step = '0;
        s.timestamp = hot_ts[k] + step;
        if (r < 85 || r >= 90)
            hot_ts[k] = s.timestamp;

        // Value change relative to the deadband.
        r = $urandom_range(0, 99);
        if (r < 30)
            dv = '0;
        else if (r < 50)
            dv = VAL_W'(mir_deadband);
        else if (r < 70)
            dv = VAL_W'(mir_deadband) + VAL_W'(1);
        else if (r < 90)
            dv = VAL_W'($urandom_range(0, 255));
        else
            dv = VAL_W'({$urandom, $urandom});
        s.value = $urandom_range(0, 1) ? hot_val[k] + dv : hot_val[k] - dv;

        if ($urandom_range(0, 99) < 10)
            hot_vp[k] = ~hot_vp[k];
        if ($urandom_range(0, 99) < 15)
            hot_qp[k] = ~hot_qp[k];
        if ($urandom_range(0, 99) < 15)
            hot_q[k] = QUAL_W'($urandom);
        if ($urandom_range(0, 99) < 20)
            hot_oth[k] = $urandom;
        hot_val[k]        = s.value;
        s.value_present   = hot_vp[k];
        s.other_code      = hot_oth[k];
        s.quality         = hot_q[k];
        s.quality_present = hot_qp[k];
        return s;
    endfunction

    // Offer one sample after a random gap and wait for its transfer.
    task automatic send_sample(input item_t s);
        int unsigned gap;
        int unsigned r;
        verdict_t    v;
        r = $urandom_range(0, 99);
        if (!tx_gaps || r < 60)
            gap = 0;
        else if (r < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, s.quality, s.other_code, s.value, s.timestamp, s.channel};
        s_axis_tuser  <= {s.quality_present, s.value_present};
        do
            @(posedge clk);
        while (!s_axis_tready);
        v.keep    = judge_sample(s);
        v.channel = s.channel;
        pending_verdicts.insert(pending_verdicts.size(), v);
    endtask

    // Stop sending and wait until every outstanding result has come back.
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        case (idx)
            CFG_ENABLE:       mir_enable   = d[0];
            CFG_DEADBAND:     mir_deadband = d[DB_W-1:0];
            CFG_MIN_INTERVAL: mir_min      = d[IVL_W-1:0];
            CFG_MAX_INTERVAL: mir_max      = d[IVL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [CFG_DATA_W-1:0] en, input logic [CFG_DATA_W-1:0] db,
                                input logic [CFG_DATA_W-1:0] mn,
                                input logic [CFG_DATA_W-1:0] mx);
        write_reg(CFG_ENABLE, en);
        write_reg(CFG_DEADBAND, db);
        write_reg(CFG_MIN_INTERVAL, mn);
        write_reg(CFG_MAX_INTERVAL, mx);
        cfg_we <= 1'b0;
    endtask

    // Reset configuration: first log, interval gating, quality and value
    // presence, digest compare, time going backwards, zero timestamp, extremes.
    task automatic test_first_samples();
        send_sample(make_sample(5, 1000, 100, 1, 0, 192, 1));
        send_sample(make_sample(5, 1100, 100, 1, 0, 192, 1));
        send_sample(make_sample(5, 1300, 101, 1, 0, 192, 1));
        send_sample(make_sample(5, 1400, 101, 1, 0, 0, 1));
        send_sample(make_sample(5, 1700, 101, 1, 0, 0, 0));
        send_sample(make_sample(5, 1800, 101, 1, 0, 5, 0));
        send_sample(make_sample(5, 900, 5000, 1, 0, 0, 0));
        send_sample(make_sample(5, 61700, 101, 1, 0, 0, 0));
        send_sample(make_sample(6, 10, 0, 0, 7, 0, 0));
        send_sample(make_sample(6, 400, 0, 0, 7, 0, 0));
        send_sample(make_sample(6, 700, 0, 0, 8, 0, 0));
        send_sample(make_sample(6, 1000, 0, 1, 8, 0, 0));
        send_sample(make_sample(9, 0, 3, 1, 0, 0, 0));
        send_sample(make_sample(9, 1, 3, 1, 0, 0, 0));
        send_sample(make_sample(1023, 48'hFFFF_FFFF_FFFF, 48'h8000_0000_0000, 1,
                                32'hFFFF_FFFF, 16'hFFFF, 1));
        send_sample(make_sample(1023, 48'hFFFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 1,
                                32'hFFFF_FFFF, 16'hFFFF, 1));
        send_sample(make_sample(0, 1, 48'h7FFF_FFFF_FFFF, 1, 0, 0, 0));
    endtask

    // A change equal to the deadband is not enough; one more counts.
    task automatic test_deadband_threshold();
        quiesce();
        program_regs(1, 1000, 0, 47'h0_FFFF_FFFF);
        send_sample(make_sample(7, 5, 0, 1, 0, 0, 0));
        send_sample(make_sample(7, 6, 1000, 1, 0, 0, 0));
        send_sample(make_sample(7, 7, -48'sd1001, 1, 0, 0, 0));
        send_sample(make_sample(7, 8, 0, 1, 0, 0, 0));
        quiesce();
        program_regs(1, 47'h7FFF_FFFF_FFFF, 0, 47'h0_FFFF_FFFF);
        send_sample(make_sample(7, 9, 48'h7FFF_FFFF_FFFF, 1, 0, 0, 0));
        send_sample(make_sample(7, 10, 48'h8000_0000_0000, 1, 0, 0, 0));
    endtask

    // One configuration, random traffic, and a full drain halfway through.
    task automatic test_random_traffic(input logic [CFG_DATA_W-1:0] en,
                                       input logic [CFG_DATA_W-1:0] db,
                                       input logic [CFG_DATA_W-1:0] mn,
                                       input logic [CFG_DATA_W-1:0] mx,
                                       input int count, input bit gaps, input bit stalls);
        quiesce();
        program_regs(en, db, mn, mx);
        seed_pool();
        tx_gaps   = gaps;
        rx_stalls = stalls;
        for (int i = 0; i < count; i++)
        begin
            send_sample(next_sample());
            if (i == count / 2)
                quiesce();
        end
        quiesce();
    endtask

    // Filtering off: every sample is kept whatever its history.
    task automatic test_filter_bypass();
        logic [CFG_DATA_W-1:0] en;
        en    = CFG_DATA_W'({$urandom, $urandom});
        en[0] = 1'b0;
        test_random_traffic(en, CFG_DATA_W'($urandom_range(0, 1000)), 250, 60000, 150, 1, 1);
    endtask

    // Receiver backpressure: random stretches of ready low and high.
    always @(posedge clk)
    begin
        if (!rx_stalls)
        begin
            m_axis_tready <= 1'b1;
            rdy_hold      <= 0;
        end
        else if (rdy_hold != 0)
        begin
            rdy_hold <= rdy_hold - 1;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(0, 99) < 70);
            rdy_hold      <= ($urandom_range(0, 99) < 90) ? $urandom_range(0, 3)
                                                          : $urandom_range(10, 40);
        end
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result for channel %0d",
                                          m_axis_tdata[CH_W-1:0]));
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (m_axis_tdata[CH_W-1:0] !== want.channel)
                    report_mismatch($sformatf("out_channel %0d, expected %0d",
                                              m_axis_tdata[CH_W-1:0], want.channel));
                if (m_axis_tuser[0] !== want.keep)
                    report_mismatch($sformatf("keep %b for channel %0d, expected %b",
                                              m_axis_tuser[0], want.channel, want.keep));
            end
        end
    end

    // Ends the run when no transfer happens for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[%0t] ERROR: no transfer for %0d cycles", $realtime, idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin : main
        logic [CFG_DATA_W-1:0] junk;
        for (int c = 0; c < CHANNELS; c++)
        begin
            st_time[c]  = '0;
            st_value[c] = '0;
            st_vv[c]    = 1'b0;
            st_other[c] = '0;
            st_qual[c]  = '0;
            st_qv[c]    = 1'b0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_samples();
        test_deadband_threshold();
        test_filter_bypass();
        test_random_traffic(1, 0, 250, 60000, 200, 1, 1);
        test_random_traffic(1, CFG_DATA_W'($urandom_range(1, 4000)) << 16,
                            CFG_DATA_W'($urandom_range(0, 400)),
                            CFG_DATA_W'($urandom_range(1000, 6000)), 220, 1, 1);
        test_random_traffic(1, 0, 47'h0_FFFF_FFFF, 0, 200, 0, 0);
        test_random_traffic(1, 47'h7FFF_FFFF_FFFF, 0, 47'h0_FFFF_FFFF, 200, 1, 0);
        junk    = CFG_DATA_W'({$urandom, $urandom});
        junk[0] = 1'b1;
        test_random_traffic(junk, CFG_DATA_W'({$urandom, $urandom}),
                            {15'($urandom), 32'($urandom)},
                            {15'($urandom), 32'($urandom)}, 230, 0, 1);

        quiesce();
        repeat (8) @(posedge clk);
        if (pending_verdicts.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_verdicts.size()));
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
